// ===== rtl/core/phr_pkg.sv =====
// ----------------------------------------------------------------------------
// phr_pkg
// Shared types and fixed constants for the pixel hue rotation pipeline.
// ----------------------------------------------------------------------------
package phr_pkg;

  // Channel and hue widths fixed by the pixel format
  localparam int unsigned ChanW  = 8;
  localparam int unsigned DegW   = 9;
  // 60 * num with num <= 7 * 255 needs 17 bits
  localparam int unsigned ProdW  = 17;
  localparam int unsigned Deg360 = 360;

  typedef logic [ChanW-1:0] chan_t;

  // Pixel sideband that rides along the pipeline
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
    chan_t mx;
    chan_t mn;
    chan_t delta;
    logic  gray;
  } pix_t;

  // Finished output pixel
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } rgba_t;

endpackage

// ===== rtl/core/phr_prep.sv =====
// ----------------------------------------------------------------------------
// phr_prep
// Entry stage: finds max, min and spread of the pixel and forms the scaled
// hue numerator 60 * num for the divider.
// ----------------------------------------------------------------------------
module phr_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  phr_pkg::chan_t red_i,
  input  phr_pkg::chan_t green_i,
  input  phr_pkg::chan_t blue_i,
  input  phr_pkg::chan_t alpha_i,
  output logic           valid_o,
  output phr_pkg::pix_t  pix_o,
  output logic [phr_pkg::ProdW-1:0] prod_o
);
  import phr_pkg::*;

  chan_t            mx, mn, delta;
  logic [10:0]      num;
  logic [ProdW-1:0] prod_d;
  pix_t             pix_d;
  logic             valid_q;
  pix_t             pix_q;
  logic [ProdW-1:0] prod_q;

  // Pick max and min; for the hue numerator red wins ties over green, green over blue
  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    if (blue_i > mx) mx = blue_i;
    mn = (red_i < green_i) ? red_i : green_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;
    if (red_i == mx) begin
      num = 11'(green_i) + 11'(delta) * 11'd6 - 11'(blue_i);
    end else if (green_i == mx) begin
      num = 11'(blue_i) + 11'(delta) * 11'd2 - 11'(red_i);
    end else begin
      num = 11'(red_i) + 11'(delta) * 11'd4 - 11'(green_i);
    end
    prod_d = ProdW'(num) * ProdW'(60);
    pix_d  = '{red: red_i, green: green_i, blue: blue_i, alpha: alpha_i,
               mx: mx, mn: mn, delta: delta, gray: (delta == '0)};
  end

  // Advance valid with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q  <= pix_d;
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;
  assign prod_o  = prod_q;

endmodule

// ===== rtl/core/phr_hue_div.sv =====
// ----------------------------------------------------------------------------
// phr_hue_div
// Pipelined restoring divider: hue = (60 * num * 2^F) / delta, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module phr_hue_div #(
  parameter int unsigned HUE_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  phr_pkg::pix_t               pix_i,
  input  logic [phr_pkg::ProdW-1:0]   prod_i,
  output logic                        valid_o,
  output phr_pkg::pix_t               pix_o,
  output logic [HUE_FRAC_BITS+8:0]    hue_o
);
  import phr_pkg::*;

  // Quotient is at most 420 * 2^F, so only the low F+9 bits are produced.
  // The top 8 dividend bits are then known to be below delta and seed the
  // remainder directly.
  localparam int unsigned QuoW   = HUE_FRAC_BITS + 9;
  localparam int unsigned Stages = QuoW;
  localparam int unsigned DvdW   = ProdW - ChanW;

  logic              vld_q [Stages];
  chan_t             rem_q [Stages];
  logic [DvdW-1:0]   dvd_q [Stages];
  logic [QuoW-1:0]   quo_q [Stages];
  pix_t              pix_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic            cur_vld;
    chan_t           cur_rem;
    logic [DvdW-1:0] cur_dvd;
    logic [QuoW-1:0] cur_quo;
    pix_t            cur_pix;
    logic [ChanW:0]  trial;
    logic            hit;

    if (s == 0) begin : g_first
      assign cur_vld = valid_i;
      assign cur_rem = prod_i[ProdW-1:DvdW];
      assign cur_dvd = prod_i[DvdW-1:0];
      assign cur_quo = '0;
      assign cur_pix = pix_i;
    end else begin : g_next
      assign cur_vld = vld_q[s-1];
      assign cur_rem = rem_q[s-1];
      assign cur_dvd = dvd_q[s-1];
      assign cur_quo = quo_q[s-1];
      assign cur_pix = pix_q[s-1];
    end

    // Shift in the next dividend bit and try a subtract
    assign trial = {cur_rem, cur_dvd[DvdW-1]};
    assign hit   = (trial >= {1'b0, cur_pix.delta});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= hit ? ChanW'(trial - {1'b0, cur_pix.delta}) : trial[ChanW-1:0];
        dvd_q[s] <= {cur_dvd[DvdW-2:0], 1'b0};
        quo_q[s] <= {cur_quo[QuoW-2:0], hit};
        pix_q[s] <= cur_pix;
      end
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign pix_o   = pix_q[Stages-1];
  assign hue_o   = quo_q[Stages-1];

endmodule

// ===== rtl/core/phr_rebuild.sv =====
// ----------------------------------------------------------------------------
// phr_rebuild
// Wraps the hue, applies the rotation, splits it into sextant and ramp and
// rebuilds the middle channel and the channel order.
// ----------------------------------------------------------------------------
module phr_rebuild #(
  parameter int unsigned HUE_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [phr_pkg::DegW-1:0]  shift_i,
  input  logic                      valid_i,
  input  phr_pkg::pix_t             pix_i,
  input  logic [HUE_FRAC_BITS+8:0]  hue_i,
  output logic                      valid_o,
  output phr_pkg::rgba_t            rgba_o
);
  import phr_pkg::*;

  localparam int unsigned F       = HUE_FRAC_BITS;
  localparam int unsigned HueW    = F + 9;
  localparam int unsigned RampW   = F + 6;
  localparam int unsigned MulW    = F + 14;
  localparam int unsigned QuotW   = 25;
  localparam logic [HueW:0]    Deg360Fix = (HueW+1)'(Deg360) << F;
  localparam logic [RampW-1:0] Deg60Fix  = RampW'(60) << F;
  // floor(z * 4370 / 2^16) == floor(z / 15) for every z below 3840
  localparam logic [QuotW-1:0] Recip15   = QuotW'(4370);

  logic [3:0]        vld_q;
  pix_t              pix1_q, pix2_q, pix3_q, pix4_q;
  logic [HueW-1:0]   h1_d, h1_q, h2_d, h2_q;
  logic [HueW:0]     sum;
  logic [DegW-1:0]   hue_int;
  logic [2:0]        sext_d, sext3_q, sext4_q;
  logic [DegW-1:0]   q_int;
  logic [RampW-1:0]  q_fix, ramp_d, ramp_q;
  logic [MulW-1:0]   prod_q;
  logic [11:0]       quarter;
  logic [QuotW-1:0]  scaled;
  chan_t             mid;
  rgba_t             rgba;

  // Fold a hue at or past 360 degrees back into range
  assign h1_d = ({1'b0, hue_i} >= Deg360Fix) ? HueW'({1'b0, hue_i} - Deg360Fix) : hue_i;

  // Add the rotation and wrap again
  assign sum  = {1'b0, h1_q} + ((HueW+1)'(shift_i) << F);
  assign h2_d = (sum >= Deg360Fix) ? HueW'(sum - Deg360Fix) : sum[HueW-1:0];

  // Split into sextant and position within it; odd sextants ramp down
  always_comb begin
    hue_int = h2_q[HueW-1:F];
    if (hue_int >= DegW'(300))      sext_d = 3'd5;
    else if (hue_int >= DegW'(240)) sext_d = 3'd4;
    else if (hue_int >= DegW'(180)) sext_d = 3'd3;
    else if (hue_int >= DegW'(120)) sext_d = 3'd2;
    else if (hue_int >= DegW'(60))  sext_d = 3'd1;
    else                            sext_d = 3'd0;
    q_int  = hue_int - DegW'(sext_d) * DegW'(60);
    q_fix  = {q_int[5:0], h2_q[F-1:0]};
    ramp_d = sext_d[0] ? (Deg60Fix - q_fix) : q_fix;
  end

  // Advance valid bits with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h1_q    <= h1_d;
      pix1_q  <= pix_i;
      h2_q    <= h2_d;
      pix2_q  <= pix1_q;
      ramp_q  <= ramp_d;
      sext3_q <= sext_d;
      pix3_q  <= pix2_q;
      prod_q  <= MulW'(pix3_q.delta) * MulW'(ramp_q);
      sext4_q <= sext3_q;
      pix4_q  <= pix3_q;
    end
  end

  // mid = mn + floor(delta * ramp / (60 * 2^F)) via shift and reciprocal
  always_comb begin
    quarter = prod_q[F+13:F+2];
    scaled  = QuotW'(quarter) * Recip15;
    mid     = pix4_q.mn + scaled[23:16];
    rgba.alpha = pix4_q.alpha;
    case (sext4_q)
      3'd0: begin
        rgba.red = pix4_q.mx;  rgba.green = mid;       rgba.blue = pix4_q.mn;
      end
      3'd1: begin
        rgba.red = mid;        rgba.green = pix4_q.mx; rgba.blue = pix4_q.mn;
      end
      3'd2: begin
        rgba.red = pix4_q.mn;  rgba.green = pix4_q.mx; rgba.blue = mid;
      end
      3'd3: begin
        rgba.red = pix4_q.mn;  rgba.green = mid;       rgba.blue = pix4_q.mx;
      end
      3'd4: begin
        rgba.red = mid;        rgba.green = pix4_q.mn; rgba.blue = pix4_q.mx;
      end
      default: begin
        rgba.red = pix4_q.mx;  rgba.green = pix4_q.mn; rgba.blue = mid;
      end
    endcase
    // Gray pixels pass unchanged
    if (pix4_q.gray) begin
      rgba.red   = pix4_q.red;
      rgba.green = pix4_q.green;
      rgba.blue  = pix4_q.blue;
    end
  end

  assign valid_o = vld_q[3];
  assign rgba_o  = rgba;

endmodule

// ===== rtl/core/pixel_hue_rotate_core.sv =====
// ----------------------------------------------------------------------------
// pixel_hue_rotate_core
// Rotates the hue of an RGBA8888 pixel stream by a programmed angle, keeping
// saturation, lightness and alpha.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in        sink       in_valid_i/in_stall_o  red/green/blue/alpha_in_i
//  out       source     out_valid_o/out_stall_i red/green/blue/alpha_out_o
//  cfg       sink       cfg_valid_i/cfg_ready_o cfg_hue_shift_i (degrees)
//
// One pixel per clock is accepted and delivered in steady state while out_stall_i is low.
// The divider resolves one hue bit per stage.
// Reset clears all valid bits and sets the rotation to zero.
// A stall on the output holds the whole pipeline; a two-entry output buffer
// catches the one request in flight, so in_stall_o comes from a register.
// ----------------------------------------------------------------------------
module pixel_hue_rotate_core #(
  parameter int unsigned HUE_FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [phr_pkg::DegW-1:0] cfg_hue_shift_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  phr_pkg::chan_t           red_in_i,
  input  phr_pkg::chan_t           green_in_i,
  input  phr_pkg::chan_t           blue_in_i,
  input  phr_pkg::chan_t           alpha_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output phr_pkg::chan_t           red_out_o,
  output phr_pkg::chan_t           green_out_o,
  output phr_pkg::chan_t           blue_out_o,
  output phr_pkg::chan_t           alpha_out_o
);
  import phr_pkg::*;

  logic [DegW-1:0]        shift_q;
  logic                   en;
  logic                   prep_valid, div_valid, pipe_valid;
  pix_t                   prep_pix, div_pix;
  logic [ProdW-1:0]       prep_prod;
  logic [HUE_FRAC_BITS+8:0] div_hue;
  rgba_t                  pipe_rgba;
  logic                   out_valid_q, skid_valid_q;
  rgba_t                  out_q, skid_q;
  logic                   take, emit;

  // Store the rotation already reduced below 360
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else if (cfg_valid_i) begin
      shift_q <= (cfg_hue_shift_i >= DegW'(Deg360)) ?
                 DegW'(cfg_hue_shift_i - DegW'(Deg360)) : cfg_hue_shift_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Pipeline moves whenever the spare output entry is free
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  phr_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .red_i   (red_in_i),
    .green_i (green_in_i),
    .blue_i  (blue_in_i),
    .alpha_i (alpha_in_i),
    .valid_o (prep_valid),
    .pix_o   (prep_pix),
    .prod_o  (prep_prod)
  );

  phr_hue_div #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_hue_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_valid),
    .pix_i   (prep_pix),
    .prod_i  (prep_prod),
    .valid_o (div_valid),
    .pix_o   (div_pix),
    .hue_o   (div_hue)
  );

  phr_rebuild #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_rebuild (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .shift_i (shift_q),
    .valid_i (div_valid),
    .pix_i   (div_pix),
    .hue_i   (div_hue),
    .valid_o (pipe_valid),
    .rgba_o  (pipe_rgba)
  );

  assign take = out_valid_q && !out_stall_i;
  assign emit = en && pipe_valid;

  // Output register with a spare entry for the request caught in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= emit;
      end
    end else if (emit) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_q <= skid_valid_q ? skid_q : pipe_rgba;
    end else if (emit) begin
      skid_q <= pipe_rgba;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_q.red;
  assign green_out_o = out_q.green;
  assign blue_out_o  = out_q.blue;
  assign alpha_out_o = out_q.alpha;

endmodule
